// ----- rtl/tpi_pkg.sv -----
// ----------------------------------------------------------------------------
// tpi_pkg: shared types for the precharge interlock
// Beat layouts of the tick and result channels, the failure cause codes and
// the configuration register map.
// ----------------------------------------------------------------------------
package tpi_pkg;

  // One timebase tick with the sampled interlock pins.
  typedef struct packed {
    logic shutdown_power_ok;
    logic tson_fault;
    logic hv_present;
    logic arm_button;
    logic pchg_done;
    logic pack_safe;
  } tpi_in_t;

  // Failure cause detected on a tick.
  typedef enum logic [1:0] {
    CAUSE_NONE       = 2'd0,
    CAUSE_DONE_STUCK = 2'd1,
    CAUSE_TIMEOUT    = 2'd2
  } fail_cause_t;

  // Levels and events reported for one tick.
  typedef struct packed {
    logic        armed_out;
    logic        precharge_fail_out;
    logic        ev_disarmed;
    logic        ev_armed;
    logic        ev_press_ignored;
    logic        ev_precharge_started;
    logic        ev_precharge_ok;
    fail_cause_t fail_cause;
  } tpi_out_t;

  // Register map: index is the byte address divided by four.
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam logic        REG_TIMEOUT = 1'b0;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

endpackage

// ----- rtl/tpi_in_if.sv -----
// ----------------------------------------------------------------------------
// tpi_in_if: tick channel
// Valid/ready channel carrying one sampled tick per beat.
// ----------------------------------------------------------------------------
interface tpi_in_if;
  import tpi_pkg::*;

  logic    valid;
  logic    ready;
  tpi_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tpi_out_if.sv -----
// ----------------------------------------------------------------------------
// tpi_out_if: result channel
// Valid/ready channel carrying one tick result per beat.
// ----------------------------------------------------------------------------
interface tpi_out_if;
  import tpi_pkg::*;

  logic     valid;
  logic     ready;
  tpi_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tson_precharge_interlock.sv -----
// ----------------------------------------------------------------------------
// tson_precharge_interlock: tractive-system-on latch with precharge watchdog
// Arms on a qualified button edge, drops on lost shutdown power or a fault,
// and latches a hard failure when precharge-done is stuck or late.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on in_beat is one timebase tick carrying the sampled interlock
// pins and the pack-safe verdict. Each tick produces exactly one beat on
// out_beat with the armed and failure levels plus the events of that tick.
// The precharge timeout (in ticks) is set through the APB port at byte
// address 0; program it only while no tick is in flight.
// A tick first lands in the input register, then the interlock update writes
// the state and the result register together. Throughput is one tick per
// cycle while out_beat is not stalled; the only loop is the state update
// (latch, counter and compare).
// When the receiver stalls, the result register holds its beat and the input
// register holds one more tick; in_beat.ready then falls until out_beat
// drains. Reset clears the latch, timer and failure latch, treats the button
// as held (a press held through reset gives no edge) and loads the timeout
// with 5000 ticks. The failure latch clears only at reset.
// ----------------------------------------------------------------------------
module tson_precharge_interlock #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tpi_in_if.sink                          in_beat,
  tpi_out_if.source                       out_beat,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tpi_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tpi_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tpi_pkg::*;

  // The elapsed counter and the timeout are compared at the wider width.
  localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Configuration register.
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 cfg_wr;

  // Input register.
  logic    in_valid_r;
  tpi_in_t in_data_r;

  // Result register.
  logic     out_valid_r;
  tpi_out_t out_data_r;
  tpi_out_t out_data_nxt;

  // Interlock state.
  logic                  armed_r, armed_nxt;
  logic                  button_prev_r;
  logic                  timer_running_r, timer_running_nxt;
  logic                  fail_latched_r, fail_latched_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;

  // Handshake.
  logic out_load;
  logic step;

  // --------------------------------------------------------------------------
  // APB register port. Writes complete without wait states; reads are zero
  // outside the register list.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
  assign prdata = (paddr[2] == REG_TIMEOUT) ? CFG_DATA_W'(timeout_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_r <= pwdata[TIMEOUT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The result register loads when it is empty or being
  // drained; the input register advances whenever the result register loads.
  // --------------------------------------------------------------------------
  assign out_load      = !out_valid_r || out_beat.ready;
  assign step          = in_valid_r && out_load;
  assign in_beat.ready = !in_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_beat.ready) begin
      in_valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      in_data_r <= in_beat.data;
    end
  end

  // --------------------------------------------------------------------------
  // Interlock update for one tick, in the order the firmware applies it:
  // count, drop, button edge, arming action, disarm stop, done/timeout check.
  // --------------------------------------------------------------------------
  always_comb begin
    logic                  elapsed_inc;
    logic                  drop;
    logic                  armed_a;
    logic                  rising;
    logic                  arm_ok;
    logic                  arm_ev;
    logic                  cause_stuck;
    logic                  start;
    logic                  run_b;
    logic                  fail_b;
    logic                  timed_out;
    logic [TIMER_BITS-1:0] elapsed_b;

    elapsed_inc = (elapsed_r != TIMER_MAX);

    drop    = armed_r && (!in_data_r.shutdown_power_ok || in_data_r.tson_fault);
    armed_a = armed_r && !drop;

    rising = in_data_r.arm_button && !button_prev_r;
    arm_ok = in_data_r.pack_safe && !in_data_r.hv_present &&
             in_data_r.shutdown_power_ok && !in_data_r.tson_fault;
    arm_ev = !armed_a && rising && arm_ok;

    armed_nxt = armed_a || arm_ev;

    // A new arming either sees done already high or starts the timer.
    cause_stuck = arm_ev && in_data_r.pchg_done;
    start       = arm_ev && !in_data_r.pchg_done;
    fail_b      = fail_latched_r || cause_stuck;
    run_b       = start || (armed_nxt && timer_running_r);
    elapsed_b   = start ? '0 : (elapsed_inc ? elapsed_r + 1'b1 : elapsed_r);

    timed_out = (CMP_W'(elapsed_b) >= CMP_W'(timeout_r));

    timer_running_nxt = run_b;
    fail_latched_nxt  = fail_b;
    elapsed_nxt       = elapsed_b;

    out_data_nxt                      = '0;
    out_data_nxt.ev_disarmed          = drop;
    out_data_nxt.ev_armed             = arm_ev;
    out_data_nxt.ev_press_ignored     = !armed_a && rising && !arm_ok;
    out_data_nxt.ev_precharge_started = start;
    out_data_nxt.fail_cause           = cause_stuck ? CAUSE_DONE_STUCK : CAUSE_NONE;

    if (run_b && !fail_b) begin
      if (in_data_r.pchg_done) begin
        timer_running_nxt            = 1'b0;
        out_data_nxt.ev_precharge_ok = 1'b1;
      end else if (timed_out) begin
        fail_latched_nxt        = 1'b1;
        out_data_nxt.fail_cause = CAUSE_TIMEOUT;
      end
    end

    out_data_nxt.armed_out          = armed_nxt;
    out_data_nxt.precharge_fail_out = fail_latched_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r         <= 1'b0;
      button_prev_r   <= 1'b1;
      timer_running_r <= 1'b0;
      fail_latched_r  <= 1'b0;
      elapsed_r       <= '0;
    end else if (step) begin
      armed_r         <= armed_nxt;
      button_prev_r   <= in_data_r.arm_button;
      timer_running_r <= timer_running_nxt;
      fail_latched_r  <= fail_latched_nxt;
      elapsed_r       <= elapsed_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_beat.valid = out_valid_r;
  assign out_beat.data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fail_latched_r |=> fail_latched_r)
    else $error("failure latch cleared without reset");

  a_timer_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    timer_running_r |-> armed_r)
    else $error("precharge timer running while disarmed");

  a_armed_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.ev_armed |-> out_data_r.armed_out)
    else $error("arming event without armed level");

  a_start_from_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.ev_precharge_started |-> out_data_r.ev_armed)
    else $error("precharge started without arming");

  a_cause_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.fail_cause != CAUSE_NONE) |->
      out_data_r.precharge_fail_out)
    else $error("failure cause reported without failure latch");

endmodule
